@@ hw/rtl/uts_pkg.sv @@
// Shared types and codes for the card identifier set table.
package uts_pkg;

   localparam int unsigned KIND_W   = 2;
   localparam int unsigned ID_W     = 32;
   localparam int unsigned STATUS_W = 3;
   localparam int unsigned INDEX_W  = 6;
   localparam int unsigned COUNT_W  = 7;

   // Item kinds; the unused code behaves as a lookup
   localparam logic [KIND_W-1:0] KIND_TOGGLE = 2'd0;
   localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd1;
   localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

   // Result status codes
   localparam logic [STATUS_W-1:0] STATUS_ADDED    = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_REMOVED  = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL     = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_FOUND    = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_NOTFOUND = 3'd4;
   localparam logic [STATUS_W-1:0] STATUS_CLEARED  = 3'd5;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [ID_W-1:0]   card_id;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [INDEX_W-1:0]  entry_index;
      logic [COUNT_W-1:0]  entry_count;
   } rsp_type;

   typedef enum logic [1:0] {
      STATE_IDLE,
      STATE_SCAN,
      STATE_MOVE
   } state_type;

endpackage

@@ hw/rtl/uid_toggle_set_table.sv @@
// Top level of the card identifier set table: store, sequencer and result register.
//
//   channel | direction | handshake           | word
//   req     | in        | req_valid/req_ready | kind, card_id
//   rsp     | out       | rsp_valid/rsp_ready | status, entry_index, entry_count
//
// A clear, or any item on an empty table, has its result registered in the cycle after acceptance.
// Lookup and toggle scan the store one entry a cycle through the single read port;
// on a removal the move state then fills the freed slot with the last entry.
// Reset empties the table at once; the entries themselves are not cleared.
// A new word is taken only when the sequencer is idle and the result register is
// free or being emptied in that cycle; a stalled result holds the sequencer idle.
module uid_toggle_set_table #(
   parameter int unsigned ENTRIES = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  uts_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output uts_pkg::rsp_type rsp_data
);

   localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int unsigned CW = $clog2(ENTRIES + 1);

   logic                     out_free;
   logic                     done;
   uts_pkg::rsp_type         result;
   logic                     mem_we;
   logic [IW-1:0]            mem_waddr;
   logic [uts_pkg::ID_W-1:0] mem_wdata;
   logic [IW-1:0]            mem_raddr;
   logic [uts_pkg::ID_W-1:0] mem_rdata;

   logic             rsp_valid_ff, rsp_valid_in;
   uts_pkg::rsp_type rsp_data_ff, rsp_data_in;

   uts_ram #(
      .DEPTH (ENTRIES),
      .AW    (IW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   uts_ctrl #(
      .ENTRIES (ENTRIES),
      .IW      (IW),
      .CW      (CW)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .out_free  (out_free),
      .done      (done),
      .result    (result),
      .mem_we    (mem_we),
      .mem_waddr (mem_waddr),
      .mem_wdata (mem_wdata),
      .mem_raddr (mem_raddr),
      .mem_rdata (mem_rdata)
   );

   // result register: load on done, drop when taken
   assign out_free     = !rsp_valid_ff || rsp_ready;
   assign rsp_valid_in = done || (rsp_valid_ff && !rsp_ready);
   assign rsp_data_in  = done ? result : rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // a word is taken only when the result register can hold its result
   a_ready_room : assert property (@(posedge clock) disable iff (reset)
      req_ready |-> (!rsp_valid_ff || rsp_ready))
      else $error("word taken while result register is occupied");

   // after a word is taken, either its result is shown or the sequencer is busy
   a_busy_after_take : assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (rsp_valid || !req_ready))
      else $error("sequencer idle after taking a word with no result");

   // an append lands at the entry just below the new count
   a_added_index : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == uts_pkg::STATUS_ADDED) |->
      (rsp_data.entry_index == uts_pkg::INDEX_W'(rsp_data.entry_count - 7'd1)))
      else $error("added entry index does not match count");

   // a clear reports an empty table
   a_cleared_empty : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == uts_pkg::STATUS_CLEARED) |->
      (rsp_data.entry_count == '0 && rsp_data.entry_index == '0))
      else $error("clear result not empty");

endmodule

@@ hw/rtl/uts_ram.sv @@
// Identifier store: one write port, one read port with registered data.
module uts_ram #(
   parameter int unsigned DEPTH = 64,
   parameter int unsigned AW    = 6
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [AW-1:0]            wr_addr,
   input  logic [uts_pkg::ID_W-1:0] wr_data,
   input  logic [AW-1:0]            rd_addr,
   output logic [uts_pkg::ID_W-1:0] rd_data
);

   logic [uts_pkg::ID_W-1:0] mem [DEPTH];
   logic [uts_pkg::ID_W-1:0] rd_data_ff;

   // write one entry
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read one entry, data registered
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/uts_ctrl.sv @@
// Sequencer: scans the store with one comparator, then appends, moves or reports.
module uts_ctrl #(
   parameter int unsigned ENTRIES = 64,
   parameter int unsigned IW      = 6,
   parameter int unsigned CW      = 7
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  uts_pkg::req_type         req_data,
   input  logic                     out_free,
   output logic                     done,
   output uts_pkg::rsp_type         result,
   output logic                     mem_we,
   output logic [IW-1:0]            mem_waddr,
   output logic [uts_pkg::ID_W-1:0] mem_wdata,
   output logic [IW-1:0]            mem_raddr,
   input  logic [uts_pkg::ID_W-1:0] mem_rdata
);

   localparam int unsigned IW1 = IW + 1;

   uts_pkg::state_type state_ff, state_in;
   logic [uts_pkg::KIND_W-1:0] kind_ff, kind_in;
   logic [uts_pkg::ID_W-1:0]   id_ff, id_in;
   logic [CW-1:0]              count_ff, count_in;
   logic [IW-1:0]              ptr_ff, ptr_in;
   logic [IW-1:0]              pos_ff, pos_in;

   logic [IW-1:0]                status_idx;
   logic [CW-1:0]                status_cnt;
   logic [uts_pkg::STATUS_W-1:0] status_code;
   logic [IW+uts_pkg::INDEX_W-1:0] idx_wide;
   logic [CW+uts_pkg::COUNT_W-1:0] cnt_wide;
   logic [IW1-1:0]               ptr_next_w;
   logic                         ptr_last;
   logic                         hit;
   logic                         full;
   logic [CW-1:0]                count_dec;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= uts_pkg::STATE_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   // item and scan registers
   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      id_ff   <= id_in;
      ptr_ff  <= ptr_in;
      pos_ff  <= pos_in;
   end

   assign ptr_next_w = IW1'(ptr_ff) + IW1'(1);
   assign ptr_last   = (ptr_next_w == IW1'(count_ff));
   assign hit        = (mem_rdata == id_ff);
   assign full       = (count_ff == CW'(ENTRIES));
   assign count_dec  = count_ff - CW'(1);

   // fit index and count to the result field widths
   assign idx_wide = {{uts_pkg::INDEX_W{1'b0}}, status_idx};
   assign cnt_wide = {{uts_pkg::COUNT_W{1'b0}}, status_cnt};
   assign result.status      = status_code;
   assign result.entry_index = idx_wide[uts_pkg::INDEX_W-1:0];
   assign result.entry_count = cnt_wide[uts_pkg::COUNT_W-1:0];

   // next state and outputs
   always_comb begin
      state_in    = state_ff;
      kind_in     = kind_ff;
      id_in       = id_ff;
      count_in    = count_ff;
      ptr_in      = ptr_ff;
      pos_in      = pos_ff;
      req_ready   = 1'b0;
      done        = 1'b0;
      status_code = uts_pkg::STATUS_NOTFOUND;
      status_idx  = '0;
      status_cnt  = count_ff;
      mem_we      = 1'b0;
      mem_waddr   = count_ff[IW-1:0];
      mem_wdata   = id_ff;
      mem_raddr   = ptr_next_w[IW-1:0];
      unique case (state_ff)
         uts_pkg::STATE_IDLE: begin
            req_ready = out_free;
            mem_raddr = '0;
            if (req_valid && out_free) begin
               kind_in = req_data.kind;
               id_in   = req_data.card_id;
               ptr_in  = '0;
               if (req_data.kind == uts_pkg::KIND_CLEAR) begin
                  // drop every entry at once
                  count_in    = '0;
                  done        = 1'b1;
                  status_code = uts_pkg::STATUS_CLEARED;
                  status_cnt  = '0;
               end else if (count_ff == '0) begin
                  // empty table: nothing to scan
                  done = 1'b1;
                  if (req_data.kind == uts_pkg::KIND_TOGGLE) begin
                     mem_we      = 1'b1;
                     mem_waddr   = '0;
                     mem_wdata   = req_data.card_id;
                     count_in    = CW'(1);
                     status_code = uts_pkg::STATUS_ADDED;
                     status_cnt  = CW'(1);
                  end
               end else begin
                  state_in = uts_pkg::STATE_SCAN;
               end
            end
         end
         uts_pkg::STATE_SCAN: begin
            if (hit) begin
               if (kind_ff == uts_pkg::KIND_TOGGLE) begin
                  // fetch the last entry to fill the freed slot
                  pos_in    = ptr_ff;
                  mem_raddr = count_dec[IW-1:0];
                  state_in  = uts_pkg::STATE_MOVE;
               end else begin
                  done        = 1'b1;
                  status_code = uts_pkg::STATUS_FOUND;
                  status_idx  = ptr_ff;
                  state_in    = uts_pkg::STATE_IDLE;
               end
            end else if (ptr_last) begin
               done     = 1'b1;
               state_in = uts_pkg::STATE_IDLE;
               if (kind_ff == uts_pkg::KIND_TOGGLE) begin
                  if (full) begin
                     status_code = uts_pkg::STATUS_FULL;
                  end else begin
                     // append at the end
                     mem_we      = 1'b1;
                     count_in    = count_ff + CW'(1);
                     status_code = uts_pkg::STATUS_ADDED;
                     status_idx  = count_ff[IW-1:0];
                     status_cnt  = count_ff + CW'(1);
                  end
               end
            end else begin
               ptr_in = ptr_next_w[IW-1:0];
            end
         end
         uts_pkg::STATE_MOVE: begin
            // last entry into the freed slot, shrink the table
            mem_we      = 1'b1;
            mem_waddr   = pos_ff;
            mem_wdata   = mem_rdata;
            count_in    = count_dec;
            done        = 1'b1;
            status_code = uts_pkg::STATUS_REMOVED;
            status_idx  = pos_ff;
            status_cnt  = count_dec;
            state_in    = uts_pkg::STATE_IDLE;
         end
         default: begin
            state_in = uts_pkg::STATE_IDLE;
         end
      endcase
   end

endmodule
